// File: hdl/pcof_pkg.sv
package pcof_pkg;

    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 16;
    localparam int WEIGHT_W = 17;
    localparam int CUR_W    = 27;
    localparam int W_W      = 28;
    localparam int CFG_W    = 17;
    localparam int IDX_W    = 1;

    localparam logic [IDX_W-1:0] CFG_VOLTS_PER_COUNT  = 1'd0;
    localparam logic [IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 1'd1;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd13517;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd39322;
    localparam logic [WEIGHT_W-1:0] Q16_ONE      = 17'd65536;

    typedef enum logic [1:0] {
        ST_CAL,
        ST_LOAD,
        ST_FIN,
        ST_RUN
    } pcof_state_t;

    typedef struct packed {
        logic cal_en;
        logic div_load;
        logic div_fin;
        logic s1_en;
        logic s2_en;
    } pcof_ctrl_t;

endpackage

// File: hdl/pcof_lane.sv
module pcof_lane #(
    parameter int CAL_SAMPLES = 300,
    parameter int SUM_W       = 21
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pcof_pkg::pcof_ctrl_t                   ctrl,
    input  logic                                   invert,
    input  logic        [pcof_pkg::SAMPLE_W-1:0]   sample,
    input  logic        [pcof_pkg::GAIN_W-1:0]     gain,
    input  logic        [pcof_pkg::WEIGHT_W-1:0]   alpha,
    output logic signed [pcof_pkg::CUR_W-1:0]      y
);

    localparam int SW    = pcof_pkg::SAMPLE_W;
    localparam int CW    = pcof_pkg::CUR_W;
    localparam int MAG_W = SUM_W - 1;
    localparam int SHIFT = MAG_W + $clog2(CAL_SAMPLES);
    localparam int RCP_W = MAG_W + 2;

    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    localparam logic signed [CW:0] T_MAX = (CW+1)'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [CW:0] T_MIN = (CW+1)'(-(64'sd1 <<< (CW-1)));

    function automatic logic signed [CW-1:0] sat_cur(input logic signed [CW+3:0] v);
        logic signed [CW-1:0] r;
        if (v > (CW+4)'(T_MAX))
        begin
            r = T_MAX[CW-1:0];
        end
        else if (v < (CW+4)'(T_MIN))
        begin
            r = T_MIN[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    logic signed [SW-1:0]          a;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic                          neg_reg;
    logic        [MAG_W-1:0]       mag_reg;
    logic        [MAG_W+RCP_W-1:0] prod;
    logic        [SW-1:0]          quot;
    logic        [SW-1:0]          quot_neg;
    logic signed [SW-1:0]          off_reg;

    logic signed [SW:0]      d;
    logic signed [SW:0]      dn;
    logic signed [29:0]      scaled;
    logic signed [CW-1:0]    t_reg;
    logic signed [CW-1:0]    t_next;

    logic signed [CW:0]      diff;
    logic signed [45:0]      mix;
    logic signed [CW+3:0]    y_sum;
    logic signed [CW-1:0]    y_reg;
    logic signed [CW-1:0]    y_next;

    // offset-binary to two's complement
    assign a = {~sample[SW-1], sample[SW-2:0]};

    assign sum_next = sum_reg + SUM_W'(a);

    // magnitude divided by the calibration count through a reciprocal multiply
    assign prod     = mag_reg * RCP;
    assign quot     = prod[SHIFT +: SW];
    assign quot_neg = -quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.cal_en)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_load)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
        end
        if (ctrl.div_fin)
        begin
            off_reg <= neg_reg ? quot_neg : quot;
        end
    end

    // scale stage
    assign d      = (SW+1)'(a) - (SW+1)'(off_reg);
    assign dn     = invert ? -d : d;
    assign scaled = dn * $signed({1'b0, gain});
    assign t_next = sat_cur((CW+4)'(scaled));

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            t_reg <= t_next;
        end
    end

    // filter stage: y + alpha*(t-y) >>> 16
    assign diff   = (CW+1)'(t_reg) - (CW+1)'(y_reg);
    assign mix    = diff * $signed({1'b0, alpha});
    assign y_sum  = (CW+4)'(y_reg) + (CW+4)'($signed(mix[45:16]));
    assign y_next = sat_cur(y_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg <= '0;
        end
        else if (ctrl.s2_en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: hdl/pcof_merge.sv
module pcof_merge (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [pcof_pkg::CUR_W-1:0]  y_u,
    input  logic signed [pcof_pkg::CUR_W-1:0]  y_v,
    output logic signed [pcof_pkg::CUR_W-1:0]  phase_u,
    output logic signed [pcof_pkg::CUR_W-1:0]  phase_v,
    output logic signed [pcof_pkg::W_W-1:0]    phase_w
);

    localparam int WW = pcof_pkg::W_W;
    localparam logic signed [WW:0] W_MAX = (WW+1)'((64'sd1 <<< (WW-1)) - 64'sd1);

    logic signed [WW:0]                 w_full;
    logic signed [WW-1:0]               w_sat;
    logic signed [pcof_pkg::CUR_W-1:0]  u_reg;
    logic signed [pcof_pkg::CUR_W-1:0]  v_reg;
    logic signed [WW-1:0]               w_reg;

    assign w_full = -((WW+1)'(y_u) + (WW+1)'(y_v));
    // only both inputs at the negative limit reach past the top
    assign w_sat  = (w_full > W_MAX) ? W_MAX[WW-1:0] : w_full[WW-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            u_reg <= y_u;
            v_reg <= y_v;
            w_reg <= w_sat;
        end
    end

    assign phase_u = u_reg;
    assign phase_v = v_reg;
    assign phase_w = w_reg;

endmodule

// File: hdl/phase_current_offset_filter_top.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    sample_a, sample_b
// out       output     out_valid / out_stall  phase_u, phase_v, phase_w
// cfg       input      cfg_write              cfg_index, cfg_data
//
// first CAL_SAMPLES pairs: one a cycle, summed per lane, no beat out
// then in_stall is high in ST_LOAD and ST_FIN while each lane divides its sum
// by a reciprocal multiply (load magnitude, multiply and sign)
// running: one pair a cycle unless out_stall backs up the pipe; each pair passes
// the scale, filter and output registers before out_valid rises
// reset clears counters, sums and filters; out_stall holds the output register
module phase_current_offset_filter_top #(
    parameter int CAL_SAMPLES = 300
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic        [pcof_pkg::SAMPLE_W-1:0]  sample_a,
    input  logic        [pcof_pkg::SAMPLE_W-1:0]  sample_b,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pcof_pkg::CUR_W-1:0]     phase_u,
    output logic signed [pcof_pkg::CUR_W-1:0]     phase_v,
    output logic signed [pcof_pkg::W_W-1:0]       phase_w,
    input  logic                                  cfg_write,
    input  logic        [pcof_pkg::IDX_W-1:0]     cfg_index,
    input  logic        [pcof_pkg::CFG_W-1:0]     cfg_data
);

    localparam int SUM_W  = $clog2(CAL_SAMPLES * 2048 + 1) + 1;
    localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);

    pcof_pkg::pcof_state_t state_reg;
    pcof_pkg::pcof_state_t state_next;
    pcof_pkg::pcof_ctrl_t  ctrl;

    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [pcof_pkg::GAIN_W-1:0]   gain_reg;
    logic [pcof_pkg::WEIGHT_W-1:0] weight_reg;
    logic [pcof_pkg::WEIGHT_W-1:0] alpha;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_take;
    logic                          out_load;
    logic                          last_cal;

    logic signed [pcof_pkg::CUR_W-1:0] y_u;
    logic signed [pcof_pkg::CUR_W-1:0] y_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= pcof_pkg::GAIN_RESET;
            weight_reg <= pcof_pkg::WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pcof_pkg::CFG_VOLTS_PER_COUNT:  gain_reg   <= cfg_data[pcof_pkg::GAIN_W-1:0];
                pcof_pkg::CFG_SMOOTHING_WEIGHT: weight_reg <= cfg_data;
                default:                        gain_reg   <= gain_reg;
            endcase
        end
    end

    assign alpha = (weight_reg > pcof_pkg::Q16_ONE) ? pcof_pkg::Q16_ONE : weight_reg;

    assign out_take = out_valid_reg && !out_stall;
    assign out_load = s2_valid_reg && (!out_valid_reg || out_take);
    assign last_cal = cnt_reg == CNT_W'(CAL_SAMPLES - 1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ctrl           = '0;
        ctrl.s2_en     = s1_valid_reg && (!s2_valid_reg || out_load);
        in_stall       = 1'b1;
        unique case (state_reg)
            pcof_pkg::ST_CAL:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.cal_en = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                    if (last_cal)
                    begin
                        state_next = pcof_pkg::ST_LOAD;
                    end
                end
            end
            pcof_pkg::ST_LOAD:
            begin
                ctrl.div_load = 1'b1;
                state_next    = pcof_pkg::ST_FIN;
            end
            pcof_pkg::ST_FIN:
            begin
                ctrl.div_fin = 1'b1;
                state_next   = pcof_pkg::ST_RUN;
            end
            pcof_pkg::ST_RUN:
            begin
                in_stall   = s1_valid_reg && !ctrl.s2_en;
                ctrl.s1_en = in_valid && !in_stall;
            end
            default:
            begin
                state_next = pcof_pkg::ST_CAL;
            end
        endcase
    end

    assign s1_valid_next  = ctrl.s1_en || (s1_valid_reg && !ctrl.s2_en);
    assign s2_valid_next  = ctrl.s2_en || (s2_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !out_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcof_pkg::ST_CAL;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    pcof_lane #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_lane_u (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .invert (1'b1),
        .sample (sample_a),
        .gain   (gain_reg),
        .alpha  (alpha),
        .y      (y_u)
    );

    pcof_lane #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_lane_v (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .invert (1'b0),
        .sample (sample_b),
        .gain   (gain_reg),
        .alpha  (alpha),
        .y      (y_v)
    );

    pcof_merge u_merge (
        .clk     (clk),
        .load    (out_load),
        .y_u     (y_u),
        .y_v     (y_v),
        .phase_u (phase_u),
        .phase_v (phase_v),
        .phase_w (phase_w)
    );

    assign out_valid = out_valid_reg;

endmodule
